// ===== hw/rtl/ell_pkg.sv =====
package ell_pkg;

   // Field widths of the ports
   localparam int COORD_BITS_DEF = 12;
   localparam int AXIS_W         = 12;
   localparam int CENTER_W       = 16;
   localparam int SIZE_W         = 13;
   localparam int CSR_W          = 16;

   // Internal widths
   localparam int CW      = 20;   // signed pixel coordinates
   localparam int STEP_W  = 13;   // loop counters
   localparam int SQ_W    = 2 * AXIS_W;
   localparam int MUL_W   = SQ_W + AXIS_W;
   localparam int DELTA_W = 44;
   localparam int DEC_W   = 48;

   // Commands
   localparam logic [1:0] CMD_START_OUTLINE = 2'd0;
   localparam logic [1:0] CMD_START_FILL    = 2'd1;
   localparam logic [1:0] CMD_ADVANCE       = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_TRANS_X = 2'd2;
   localparam logic [1:0] REG_TRANS_Y = 2'd3;

   // Shared unit operations
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [CENTER_W-1:0] center_x;
      logic [CENTER_W-1:0] center_y;
      logic [AXIS_W-1:0]   semi_axis_a;
      logic [AXIS_W-1:0]   semi_axis_b;
   } req_item_type;

   typedef struct packed {
      logic [CSR_W-1:0]  translate_x;
      logic [CSR_W-1:0]  translate_y;
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [DEC_W-1:0] a;
      logic [DEC_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [CW-1:0] xs;
      logic [CW-1:0] xe;
      logic [CW-1:0] y;
      logic          visible;
   } clip_res_type;

   typedef struct packed {
      logic [CW-1:0] xs;
      logic [CW-1:0] xe;
      logic [CW-1:0] y;
      logic          visible;
      logic          finished;
      logic          last;
   } emit_type;

endpackage

// ===== hw/rtl/ell_alu.sv =====
module ell_alu (
   input  ell_pkg::alu_req_type           req,
   output logic signed [ell_pkg::DEC_W-1:0] result
);
   import ell_pkg::*;

   logic [MUL_W-1:0] prod;

   // One unsigned 24x12 multiply, or one wide add or subtract
   always_comb begin
      prod = req.a[SQ_W-1:0] * req.b[AXIS_W-1:0];
      case (req.op)
         OP_ADD:  result = $signed(req.a) + $signed(req.b);
         OP_SUB:  result = $signed(req.a) - $signed(req.b);
         OP_MUL:  result = $signed(DEC_W'(prod));
         default: result = '0;
      endcase
   end

endmodule

// ===== hw/rtl/ell_clip.sv =====
module ell_clip (
   input  logic signed [ell_pkg::CW-1:0]     origin_x,
   input  logic signed [ell_pkg::CW-1:0]     origin_y,
   input  logic [ell_pkg::STEP_W-1:0]        u,
   input  logic signed [ell_pkg::STEP_W-1:0] v,
   input  logic                              region2,
   input  logic                              fill,
   input  logic [1:0]                        slot,
   input  logic [ell_pkg::SIZE_W-1:0]        width,
   input  logic [ell_pkg::SIZE_W-1:0]        height,
   output ell_pkg::clip_res_type             res
);
   import ell_pkg::*;

   logic signed [CW-1:0] px, py, pt_x, pt_y, x1, x2, lo, hi, w_s, h_s;
   logic                 xneg, yneg, row_in, vis;

   always_comb begin
      // Region two draws (dx,dy) at (dy,dx)
      px = region2 ? CW'(v) : $signed(CW'(u));
      py = region2 ? $signed(CW'(u)) : CW'(v);
      xneg = region2 ? slot[0] : slot[1];
      yneg = (fill || !region2) ? slot[0] : slot[1];
      w_s = $signed(CW'(width));
      h_s = $signed(CW'(height));

      pt_x = xneg ? origin_x - px : origin_x + px;
      pt_y = yneg ? origin_y - py : origin_y + py;
      x1 = origin_x - px;
      x2 = origin_x + px;
      lo = (x1 < 0) ? '0 : x1;
      hi = (x2 > w_s - 1) ? w_s - 1 : x2;

      row_in = (pt_y >= 0) && (pt_y < h_s);
      if (fill) begin
         vis = row_in && (lo <= hi);
         res.xs = lo;
         res.xe = hi;
      end else begin
         vis = row_in && (pt_x >= 0) && (pt_x < w_s);
         res.xs = pt_x;
         res.xe = pt_x;
      end
      res.y = pt_y;
      res.visible = vis;

      // Zero everything off target
      if (!vis) begin
         res.xs = '0;
         res.xe = '0;
         res.y  = '0;
      end
   end

endmodule

// ===== hw/rtl/ell_seq.sv =====
module ell_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ell_pkg::req_item_type in_item,
   input  ell_pkg::cfg_type      cfg,
   output logic                  emit_valid,
   input  logic                  emit_ready,
   output ell_pkg::emit_type     emit_item
);
   import ell_pkg::*;

   localparam logic [3:0] S_READY   = 4'd0;
   localparam logic [3:0] S_SQ_A    = 4'd1;
   localparam logic [3:0] S_SQ_B    = 4'd2;
   localparam logic [3:0] S_DY      = 4'd3;
   localparam logic [3:0] S_DEC0    = 4'd4;
   localparam logic [3:0] S_DEC1    = 4'd5;
   localparam logic [3:0] S_CHECK   = 4'd6;
   localparam logic [3:0] S_IT_DX   = 4'd7;
   localparam logic [3:0] S_IT_SB   = 4'd8;
   localparam logic [3:0] S_IT_DY   = 4'd9;
   localparam logic [3:0] S_IT_STEP = 4'd10;
   localparam logic [3:0] S_IT_ADV  = 4'd11;
   localparam logic [3:0] S_EMIT    = 4'd12;
   localparam logic [3:0] S_FIN     = 4'd13;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_R1   = 2'd1;
   localparam logic [1:0] PH_R2   = 2'd2;

   // Control state
   logic [3:0] st_ff, st_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] k_ff, k_in;
   logic       fill_ff, fill_in;
   logic       r2_ff, r2_in;       // region being loaded is region two
   logic       adv_ff, adv_in;     // load runs inside an advance
   logic       pos_ff, pos_in;     // decision was positive at iteration start

   // Datapath state
   logic signed [CW-1:0]      ox_ff, ox_in, oy_ff, oy_in;
   logic [AXIS_W-1:0]         axa_ff, axa_in, axb_ff, axb_in;
   logic [STEP_W-1:0]         sx_ff, sx_in, u_ff, u_in;
   logic signed [STEP_W-1:0]  sy_ff, sy_in;
   logic signed [DEC_W-1:0]   dec_ff, dec_in;
   logic signed [DELTA_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_W-1:0]           sqa_ff, sqa_in, sqb_ff, sqb_in;

   alu_req_type             alu_req;
   logic signed [DEC_W-1:0] alu_res;
   clip_res_type            clip_res;
   logic [AXIS_W-1:0]       axis_p, axis_q;
   logic                    can_iter, is_last;

   ell_alu u_alu (
      .req    (alu_req),
      .result (alu_res)
   );

   ell_clip u_clip (
      .origin_x (ox_ff),
      .origin_y (oy_ff),
      .u        (u_ff),
      .v        (sy_ff),
      .region2  (phase_ff == PH_R2),
      .fill     (fill_ff),
      .slot     (k_ff),
      .width    (cfg.width),
      .height   (cfg.height),
      .res      (clip_res)
   );

   assign in_ready = (st_ff == S_READY);
   assign axis_p   = r2_ff ? axb_ff : axa_ff;
   assign axis_q   = r2_ff ? axa_ff : axb_ff;
   assign can_iter = alu_res[DEC_W-1] && (sx_ff < cfg.width) && !sy_ff[STEP_W-1];
   assign is_last  = (k_ff == (fill_ff ? 2'd1 : 2'd3));

   // Issue one operation to the shared unit per state
   always_comb begin
      alu_req.op = OP_ADD;
      alu_req.a  = '0;
      alu_req.b  = '0;
      case (st_ff)
         S_SQ_A: begin
            alu_req.op = OP_MUL;
            alu_req.a  = DEC_W'(axis_p);
            alu_req.b  = DEC_W'(axis_p);
         end
         S_SQ_B: begin
            alu_req.op = OP_MUL;
            alu_req.a  = DEC_W'(axis_q);
            alu_req.b  = DEC_W'(axis_q);
         end
         S_DY: begin
            alu_req.op = OP_MUL;
            alu_req.a  = DEC_W'(sqa_ff);
            alu_req.b  = DEC_W'(axis_q);
         end
         S_DEC0: begin
            alu_req.a = DEC_W'({sqb_ff, 2'b00});
            alu_req.b = DEC_W'(sqa_ff);
         end
         S_DEC1: begin
            alu_req.op = OP_SUB;
            alu_req.a  = dec_ff;
            alu_req.b  = DEC_W'(dy_ff >>> 1);
         end
         S_CHECK: begin
            alu_req.op = OP_SUB;
            alu_req.a  = DEC_W'(dx_ff);
            alu_req.b  = DEC_W'(dy_ff);
         end
         S_IT_DX: begin
            alu_req.a = dec_ff;
            alu_req.b = DEC_W'(dx_ff);
         end
         S_IT_SB: begin
            alu_req.a = dec_ff;
            alu_req.b = DEC_W'({sqb_ff, 2'b00});
         end
         S_IT_DY: begin
            alu_req.op = OP_SUB;
            alu_req.a  = dec_ff;
            alu_req.b  = DEC_W'(dy_ff);
         end
         S_IT_STEP: begin
            alu_req.op = OP_SUB;
            alu_req.a  = DEC_W'(dy_ff);
            alu_req.b  = DEC_W'({sqa_ff, 3'b000});
         end
         S_IT_ADV: begin
            alu_req.a = DEC_W'(dx_ff);
            alu_req.b = DEC_W'({sqb_ff, 3'b000});
         end
         default: begin
            alu_req.op = OP_ADD;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      st_in    = st_ff;
      phase_in = phase_ff;
      k_in     = k_ff;
      fill_in  = fill_ff;
      r2_in    = r2_ff;
      adv_in   = adv_ff;
      pos_in   = pos_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      axa_in   = axa_ff;
      axb_in   = axb_ff;
      sx_in    = sx_ff;
      u_in     = u_ff;
      sy_in    = sy_ff;
      dec_in   = dec_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      sqa_in   = sqa_ff;
      sqb_in   = sqb_ff;

      emit_valid = 1'b0;
      emit_item.xs       = clip_res.xs;
      emit_item.xe       = clip_res.xe;
      emit_item.y        = clip_res.y;
      emit_item.visible  = clip_res.visible;
      emit_item.finished = 1'b0;
      emit_item.last     = is_last;

      case (st_ff)
         S_READY: begin
            if (in_valid) begin
               if (in_item.cmd == CMD_START_OUTLINE || in_item.cmd == CMD_START_FILL) begin
                  fill_in = in_item.cmd[0];
                  ox_in   = CW'($signed(in_item.center_x)) + CW'($signed(cfg.translate_x));
                  oy_in   = CW'($signed(in_item.center_y)) + CW'($signed(cfg.translate_y));
                  axa_in  = in_item.semi_axis_a;
                  axb_in  = in_item.semi_axis_b;
                  r2_in   = 1'b0;
                  adv_in  = 1'b0;
                  st_in   = S_SQ_A;
               end else if (in_item.cmd == CMD_ADVANCE) begin
                  st_in = S_CHECK;
               end
            end
         end
         // Load a region: squares, y increment, initial decision
         S_SQ_A: begin
            sqa_in = alu_res[SQ_W-1:0];
            sy_in  = $signed({1'b0, axis_q});
            sx_in  = '0;
            dx_in  = '0;
            st_in  = S_SQ_B;
         end
         S_SQ_B: begin
            sqb_in = alu_res[SQ_W-1:0];
            st_in  = S_DY;
         end
         S_DY: begin
            dy_in = $signed({alu_res[DELTA_W-4:0], 3'b000});
            st_in = S_DEC0;
         end
         S_DEC0: begin
            dec_in = alu_res;
            st_in  = S_DEC1;
         end
         S_DEC1: begin
            dec_in   = alu_res;
            phase_in = r2_ff ? PH_R2 : PH_R1;
            st_in    = adv_ff ? S_CHECK : S_READY;
         end
         // Decide: iterate, switch region, or report the end
         S_CHECK: begin
            if (phase_ff == PH_R1 && !can_iter) begin
               r2_in  = 1'b1;
               adv_in = 1'b1;
               st_in  = S_SQ_A;
            end else if (phase_ff == PH_IDLE || !can_iter) begin
               phase_in = PH_IDLE;
               st_in    = S_FIN;
            end else begin
               pos_in = !dec_ff[DEC_W-1] && (dec_ff != '0);
               st_in  = S_IT_DX;
            end
         end
         S_IT_DX: begin
            dec_in = alu_res;
            st_in  = S_IT_SB;
         end
         S_IT_SB: begin
            dec_in = alu_res;
            st_in  = pos_ff ? S_IT_DY : S_IT_ADV;
         end
         S_IT_DY: begin
            dec_in = alu_res;
            st_in  = S_IT_STEP;
         end
         S_IT_STEP: begin
            dy_in = alu_res[DELTA_W-1:0];
            sy_in = sy_ff - STEP_W'(1);
            st_in = S_IT_ADV;
         end
         S_IT_ADV: begin
            dx_in = alu_res[DELTA_W-1:0];
            u_in  = sx_ff;
            sx_in = sx_ff + STEP_W'(1);
            k_in  = '0;
            st_in = S_EMIT;
         end
         // Hand out points or spans one word at a time
         S_EMIT: begin
            emit_valid = 1'b1;
            if (emit_ready) begin
               k_in = k_ff + 2'd1;
               if (is_last) begin
                  st_in = S_READY;
               end
            end
         end
         S_FIN: begin
            emit_valid         = 1'b1;
            emit_item.xs       = '0;
            emit_item.xe       = '0;
            emit_item.y        = '0;
            emit_item.visible  = 1'b0;
            emit_item.finished = 1'b1;
            emit_item.last     = 1'b1;
            if (emit_ready) begin
               st_in = S_READY;
            end
         end
         default: begin
            st_in = S_READY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_READY;
         phase_ff <= PH_IDLE;
         k_ff     <= '0;
         fill_ff  <= 1'b0;
         r2_ff    <= 1'b0;
         adv_ff   <= 1'b0;
         pos_ff   <= 1'b0;
      end else begin
         st_ff    <= st_in;
         phase_ff <= phase_in;
         k_ff     <= k_in;
         fill_ff  <= fill_in;
         r2_ff    <= r2_in;
         adv_ff   <= adv_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      ox_ff  <= ox_in;
      oy_ff  <= oy_in;
      axa_ff <= axa_in;
      axb_ff <= axb_in;
      sx_ff  <= sx_in;
      u_ff   <= u_in;
      sy_ff  <= sy_in;
      dec_ff <= dec_in;
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      sqa_ff <= sqa_in;
      sqb_ff <= sqb_in;
   end

endmodule

// ===== hw/rtl/ellipse_rasterizer.sv =====
// Channel | Handshake             | Payload
// req     | req_tvalid/req_tready | tdata: center_x, center_y, semi_axis_a, semi_axis_b
//         |                       | tuser: cmd
// rsp     | rsp_tvalid/rsp_tready | tdata: span_x_start, span_x_end, span_y
//         |                       | tuser: visible, finished; tlast: last
// csr     | csr_valid/csr_ready   | csr_index, csr_wdata
//
// A start word computes squares, dy, decision: one shared multiply/add op per cycle.
// An advance checks, iterates (y steps on a positive decision), then gives one result
// per cycle unless rsp stalls (2 spans or 4 points); a region change reloads first.
// Reset is synchronous and leaves the block idle with 640x480 target, no offset.
// req_tready is low while an item is worked on; a stalled rsp holds the output register.
module ellipse_rasterizer #(
   parameter int COORD_BITS = ell_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // center_x[15:0], center_y[31:16], semi_axis_a[43:32], semi_axis_b[55:44]
   input  logic [55:0]                         req_tdata,
   // cmd[1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // span_x_start, span_x_end, span_y (COORD_BITS each), zero fill
   output logic [((3*COORD_BITS+7)/8)*8-1:0]   rsp_tdata,
   // visible[0], finished[1]
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [ell_pkg::CSR_W-1:0]           csr_wdata
);
   import ell_pkg::*;

   localparam int LIM = 1 << COORD_BITS;

   logic [SIZE_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [CSR_W-1:0]  tx_ff, tx_in, ty_ff, ty_in;
   logic [16:0]       lim;
   cfg_type           cfg;
   req_item_type      in_item;
   emit_type          emit_item;
   logic              emit_valid, emit_ready;

   logic                  out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0] out_xs_ff, out_xs_in, out_xe_ff, out_xe_in, out_y_ff, out_y_in;
   logic                  out_vis_ff, out_vis_in, out_fin_ff, out_fin_in, out_last_ff, out_last_in;

   assign csr_ready = 1'b1;

   // Register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      tx_in     = tx_ff;
      ty_in     = ty_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_WIDTH:   width_in  = csr_wdata[SIZE_W-1:0];
            REG_HEIGHT:  height_in = csr_wdata[SIZE_W-1:0];
            REG_TRANS_X: tx_in     = csr_wdata;
            REG_TRANS_Y: ty_in     = csr_wdata;
            default:     tx_in     = tx_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_W'(640);
         height_ff <= SIZE_W'(480);
         tx_ff     <= '0;
         ty_ff     <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         tx_ff     <= tx_in;
         ty_ff     <= ty_in;
      end
   end

   // Saturate the target size to the coordinate range
   assign lim = 17'(LIM);
   always_comb begin
      cfg.translate_x = tx_ff;
      cfg.translate_y = ty_ff;
      cfg.width  = ({4'b0, width_ff}  > lim) ? lim[SIZE_W-1:0] : width_ff;
      cfg.height = ({4'b0, height_ff} > lim) ? lim[SIZE_W-1:0] : height_ff;
   end

   assign in_item.cmd         = req_tuser;
   assign in_item.center_x    = req_tdata[15:0];
   assign in_item.center_y    = req_tdata[31:16];
   assign in_item.semi_axis_a = req_tdata[43:32];
   assign in_item.semi_axis_b = req_tdata[55:44];

   ell_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .cfg        (cfg),
      .emit_valid (emit_valid),
      .emit_ready (emit_ready),
      .emit_item  (emit_item)
   );

   // Output register: load when empty or being drained
   assign emit_ready = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_xs_in    = out_xs_ff;
      out_xe_in    = out_xe_ff;
      out_y_in     = out_y_ff;
      out_vis_in   = out_vis_ff;
      out_fin_in   = out_fin_ff;
      out_last_in  = out_last_ff;
      if (emit_ready) begin
         out_valid_in = emit_valid;
         out_xs_in    = emit_item.xs[COORD_BITS-1:0];
         out_xe_in    = emit_item.xe[COORD_BITS-1:0];
         out_y_in     = emit_item.y[COORD_BITS-1:0];
         out_vis_in   = emit_item.visible;
         out_fin_in   = emit_item.finished;
         out_last_in  = emit_item.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_xs_ff   <= out_xs_in;
      out_xe_ff   <= out_xe_in;
      out_y_ff    <= out_y_in;
      out_vis_ff  <= out_vis_in;
      out_fin_ff  <= out_fin_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[COORD_BITS-1:0]              = out_xs_ff;
      rsp_tdata[2*COORD_BITS-1:COORD_BITS]   = out_xe_ff;
      rsp_tdata[3*COORD_BITS-1:2*COORD_BITS] = out_y_ff;
   end
   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tuser[0] = out_vis_ff;
   assign rsp_tuser[1] = out_fin_ff;
   assign rsp_tlast    = out_last_ff;

   // A finished word closes the advance and carries nothing drawn
   a_fin_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && !rsp_tuser[0])
      else $error("finished word without last or with visible set");

   // Off-target words carry zero coordinates
   a_invis_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> out_xs_ff == '0 && out_xe_ff == '0 && out_y_ff == '0)
      else $error("invisible word with nonzero coordinates");

   // A visible span never runs backward
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> out_xs_ff <= out_xe_ff)
      else $error("visible span with start beyond end");

   // A start keeps the block busy while the region loads
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
      (req_tuser == CMD_START_OUTLINE || req_tuser == CMD_START_FILL) |=> !req_tready)
      else $error("ready right after a start");

endmodule
